[src/sdpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder package
// Shared widths, codes and record types of the encoder.
// ----------------------------------------------------------------------------
package sdpe_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int WORD_W           = 16;
   localparam int BITS_W           = 5;
   localparam int VCOUNT_W         = 13;
   localparam int CHCNT_W          = 5;
   localparam int PAYW_W           = 9;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 9;
   localparam int CODE_W           = 25;
   localparam int LEN_W            = 5;
   localparam int USED_W           = 4;
   localparam int TOTAL_W          = 6;
   localparam int MAX_CLASS        = 7;
   localparam int FIFO_DEPTH       = 4;
   localparam int DEF_MAX_CHANNELS = 16;
   localparam int DEF_BLOCK_WORDS  = 256;

   localparam logic [VCOUNT_W-1:0] VCOUNT_MAX  = 13'd8191;
   localparam logic [8:0]          ESC_PREFIX  = 9'd255;
   localparam logic [LEN_W-1:0]    ESC_LEN     = 5'd25;
   localparam logic [LEN_W-1:0]    RAW_LEN     = 5'd16;
   localparam logic [LEN_W-1:0]    ZERO_LEN    = 5'd1;
   localparam logic [CHCNT_W-1:0]  CHCNT_RESET = 5'd1;
   localparam logic [PAYW_W-1:0]   PAYW_RESET  = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_PAYLOAD_WORDS = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PHASE_RAW    = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } code_type;

   typedef struct packed {
      logic     fire;
      logic     flush;
      logic     vec_end;
      code_type code;
   } pack_cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0]   packed_word;
      logic [BITS_W-1:0]   bits_valid;
      logic                end_of_block;
      logic                block_full;
      logic [VCOUNT_W-1:0] vectors_in_block;
      logic                last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type w0;
      rsp_word_type w1;
   } push_type;

endpackage

[src/sdpe_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder channels
// Valid/ready channels for input samples and for packed result words.
// ----------------------------------------------------------------------------
interface sdpe_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic signed [15:0]          sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink (input valid, input op, input sample, output ready);
endinterface

interface sdpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] packed_word;
   logic [4:0]  bits_valid;
   logic        end_of_block;
   logic        block_full;
   logic [12:0] vectors_in_block;
   logic        last;

   modport source (output valid, output packed_word, output bits_valid,
                   output end_of_block, output block_full,
                   output vectors_in_block, output last, input ready);
   modport sink (input valid, input packed_word, input bits_valid,
                 input end_of_block, input block_full,
                 input vectors_in_block, input last, output ready);
endinterface

[src/second_difference_prefix_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder
// Codes interleaved 16-bit samples as raw, first or second differences with a
// prefix code and packs the bits into 16-bit words.
// ----------------------------------------------------------------------------
// A sample word is accepted in any cycle in which the input register is free,
// or is moving on because the four-word result queue has room for two words;
// its words pass through the input register and the result queue to the
// result port. Each sample yields zero, one or two words and the result port
// gives out one word per cycle, so the sustained rate, while the receiver is
// ready, is one sample per cycle while codes stay short and falls for samples
// that complete two words. The per-channel history sits in a RAM with a
// registered read that is addressed as the sample is accepted; a write to the
// same channel in the cycle of that read is forwarded. History clears on
// reset through per-channel valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module second_difference_prefix_encoder_top #(
   parameter int MAX_CHANNELS = sdpe_pkg::DEF_MAX_CHANNELS,
   parameter int BLOCK_WORDS  = sdpe_pkg::DEF_BLOCK_WORDS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sdpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sdpe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   sdpe_req_if.sink                         req_ch,
   sdpe_rsp_if.source                       rsp_ch
);

   localparam int SAMPLE_W = sdpe_pkg::SAMPLE_W;
   localparam int CHCNT_W  = sdpe_pkg::CHCNT_W;
   localparam int PAYW_W   = sdpe_pkg::PAYW_W;
   localparam int CH_W     = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
   localparam int LIM_W    = (CH_W > CHCNT_W ? CH_W : CHCNT_W) + 1;
   localparam int RAM_W    = 2 * SAMPLE_W;

   logic [CHCNT_W-1:0]    chcnt_ff;
   logic [PAYW_W-1:0]     payw_ff;

   logic [LIM_W-1:0]      cc_ext;
   logic [LIM_W-1:0]      chan_lim;
   logic [CH_W-1:0]       last_ch;
   logic [CH_W-1:0]       chan;
   logic                  at_end;
   logic                  accept;
   logic                  fire;
   logic                  room;

   logic [CH_W-1:0]       pos_ff, pos_in;
   sdpe_pkg::phase_type   phs_ff, phs_in;

   logic                  in_vld_ff, in_vld_in;
   logic                  in_op_ff;
   logic [SAMPLE_W-1:0]   in_sample_ff;
   logic [CH_W-1:0]       in_chan_ff;
   sdpe_pkg::phase_type   in_phase_ff;
   logic                  in_end_ff;

   logic [CH_W-1:0]       rd_addr;
   logic                  wr_en;
   logic [RAM_W-1:0]      wr_data;
   logic [RAM_W-1:0]      ram_rdata;
   logic [RAM_W-1:0]      hist;
   logic [MAX_CHANNELS-1:0] hist_vld_ff;
   logic                  rd_vld_ff;
   logic                  fwd_hit_ff;
   logic [RAM_W-1:0]      fwd_data_ff;

   sdpe_pkg::code_type     code;
   sdpe_pkg::pack_cmd_type cmd;
   sdpe_pkg::push_type     push;
   sdpe_pkg::rsp_word_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         chcnt_ff <= sdpe_pkg::CHCNT_RESET;
         payw_ff  <= sdpe_pkg::PAYW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sdpe_pkg::CSR_CHANNEL_COUNT: chcnt_ff <= csr_wdata[CHCNT_W-1:0];
            sdpe_pkg::CSR_PAYLOAD_WORDS: payw_ff  <= csr_wdata[PAYW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cc_ext = LIM_W'(chcnt_ff);
      if (cc_ext == '0) begin
         chan_lim = LIM_W'(1);
      end else if (cc_ext > LIM_W'(MAX_CHANNELS)) begin
         chan_lim = LIM_W'(MAX_CHANNELS);
      end else begin
         chan_lim = cc_ext;
      end
      last_ch = CH_W'(chan_lim - LIM_W'(1));
      chan    = (pos_ff > last_ch) ? last_ch : pos_ff;
      at_end  = chan == last_ch;
   end

   assign accept       = req_ch.valid && req_ch.ready;
   assign fire         = in_vld_ff && room;
   assign req_ch.ready = !in_vld_ff || fire;

   always_comb begin
      pos_in    = pos_ff;
      phs_in    = phs_ff;
      in_vld_in = in_vld_ff;
      if (fire) begin
         in_vld_in = 1'b0;
      end
      if (accept) begin
         in_vld_in = 1'b1;
         if (req_ch.op == sdpe_pkg::OP_FLUSH) begin
            pos_in = '0;
            phs_in = sdpe_pkg::PHASE_RAW;
         end else if (at_end) begin
            pos_in = '0;
            case (phs_ff)
               sdpe_pkg::PHASE_RAW:   phs_in = sdpe_pkg::PHASE_FIRST;
               sdpe_pkg::PHASE_FIRST: phs_in = sdpe_pkg::PHASE_SECOND;
               default:               phs_in = sdpe_pkg::PHASE_SECOND;
            endcase
         end else begin
            pos_in = chan + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phs_ff    <= sdpe_pkg::PHASE_RAW;
         in_vld_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         phs_ff    <= phs_in;
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff     <= req_ch.op;
         in_sample_ff <= req_ch.sample;
         in_chan_ff   <= chan;
         in_phase_ff  <= phs_ff;
         in_end_ff    <= at_end;
      end
   end

   assign rd_addr = accept ? chan : in_chan_ff;
   assign wr_en   = fire && (in_op_ff == sdpe_pkg::OP_SAMPLE);
   assign hist    = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? ram_rdata : '0);
   assign wr_data = {in_sample_ff, hist[RAM_W-1:SAMPLE_W]};

   sdpe_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (in_chan_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            hist_vld_ff[in_chan_ff] <= 1'b1;
         end
         rd_vld_ff  <= hist_vld_ff[rd_addr];
         fwd_hit_ff <= wr_en && (in_chan_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

   sdpe_coder u_coder (
      .phase    (in_phase_ff),
      .sample   (in_sample_ff),
      .prev_one (hist[RAM_W-1:SAMPLE_W]),
      .prev_two (hist[SAMPLE_W-1:0]),
      .code     (code)
   );

   always_comb begin
      cmd.fire    = fire;
      cmd.flush   = in_op_ff == sdpe_pkg::OP_FLUSH;
      cmd.vec_end = in_end_ff;
      cmd.code    = code;
   end

   sdpe_packer #(
      .BLOCK_WORDS (BLOCK_WORDS)
   ) u_packer (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .payload_words (payw_ff),
      .push          (push)
   );

   sdpe_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (rsp_ch.valid),
      .head_ready (rsp_ch.ready),
      .head       (head)
   );

   assign rsp_ch.packed_word      = head.packed_word;
   assign rsp_ch.bits_valid       = head.bits_valid;
   assign rsp_ch.end_of_block     = head.end_of_block;
   assign rsp_ch.block_full       = head.block_full;
   assign rsp_ch.vectors_in_block = head.vectors_in_block;
   assign rsp_ch.last             = head.last;

endmodule

[src/sdpe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sdpe_coder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder code generator
// Forms the difference for the vector phase and maps it to a prefix code.
// ----------------------------------------------------------------------------
module sdpe_coder (
   input  sdpe_pkg::phase_type          phase,
   input  logic [sdpe_pkg::SAMPLE_W-1:0] sample,
   input  logic [sdpe_pkg::SAMPLE_W-1:0] prev_one,
   input  logic [sdpe_pkg::SAMPLE_W-1:0] prev_two,
   output sdpe_pkg::code_type            code
);

   localparam int SAMPLE_W = sdpe_pkg::SAMPLE_W;
   localparam int CODE_W   = sdpe_pkg::CODE_W;
   localparam int LEN_W    = sdpe_pkg::LEN_W;

   logic [SAMPLE_W-1:0] diff;
   logic [SAMPLE_W-1:0] mapped;

   always_comb begin
      if (phase == sdpe_pkg::PHASE_FIRST) begin
         diff = sample - prev_one;
      end else begin
         diff = sample - {prev_one[SAMPLE_W-2:0], 1'b0} + prev_two;
      end
      mapped = diff[SAMPLE_W-1] ? diff - SAMPLE_W'(1) : diff;
   end

   always_comb begin
      logic found;
      logic signed [SAMPLE_W-1:0] high;
      found     = 1'b0;
      high      = '0;
      code.len  = sdpe_pkg::ESC_LEN;
      code.bits = {mapped, sdpe_pkg::ESC_PREFIX};
      for (int k = 1; k <= sdpe_pkg::MAX_CLASS; k++) begin
         high = $signed(mapped) >>> k;
         if (!found && ((high == '0) || (high == '1))) begin
            found     = 1'b1;
            code.len  = LEN_W'(2 * k + 1);
            code.bits = (CODE_W'(mapped & SAMPLE_W'((32'd1 << k) - 32'd1)) << (k + 1))
                        | CODE_W'((32'd1 << k) - 32'd1);
         end
      end
      if (mapped == '0) begin
         code.len  = sdpe_pkg::ZERO_LEN;
         code.bits = '0;
      end
      if (phase == sdpe_pkg::PHASE_RAW) begin
         code.len  = sdpe_pkg::RAW_LEN;
         code.bits = CODE_W'(sample);
      end
   end

endmodule

[src/sdpe_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder bit packer
// Packs codes into 16-bit words, tracks block fill and counts vectors.
// ----------------------------------------------------------------------------
module sdpe_packer #(
   parameter int BLOCK_WORDS = sdpe_pkg::DEF_BLOCK_WORDS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sdpe_pkg::pack_cmd_type       cmd,
   input  logic [sdpe_pkg::PAYW_W-1:0]  payload_words,
   output sdpe_pkg::push_type           push
);

   localparam int WORD_W   = sdpe_pkg::WORD_W;
   localparam int CODE_W   = sdpe_pkg::CODE_W;
   localparam int USED_W   = sdpe_pkg::USED_W;
   localparam int TOTAL_W  = sdpe_pkg::TOTAL_W;
   localparam int BITS_W   = sdpe_pkg::BITS_W;
   localparam int VCOUNT_W = sdpe_pkg::VCOUNT_W;
   localparam int PAYW_W   = sdpe_pkg::PAYW_W;
   localparam int CAT_W    = CODE_W + WORD_W - 1;
   localparam int WC_W     = $clog2(BLOCK_WORDS + 1);
   localparam int LW       = WC_W > PAYW_W ? WC_W : PAYW_W;

   logic [LW-1:0]       pw_ext;
   logic [WC_W-1:0]     limit;
   logic                over;
   logic [WC_W-1:0]     remaining;
   logic [CAT_W-1:0]    cat;
   logic [TOTAL_W-1:0]  total;
   logic [1:0]          nw;
   logic [1:0]          emit;
   logic                fill;

   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [WC_W-1:0]     words_ff, words_in;
   logic                full_ff, full_in;
   logic [VCOUNT_W-1:0] vcount_ff, vcount_in;

   always_comb begin
      pw_ext = LW'(payload_words);
      if (pw_ext == '0) begin
         limit = WC_W'(1);
      end else if (pw_ext > LW'(BLOCK_WORDS)) begin
         limit = WC_W'(BLOCK_WORDS);
      end else begin
         limit = WC_W'(pw_ext);
      end
      // A limit lowered below the words already sent fills the block on the next word.
      over      = words_ff >= limit;
      remaining = over ? WC_W'(1) : limit - words_ff;
      cat       = (CAT_W'(cmd.code.bits) << used_ff) | CAT_W'(acc_ff);
      total     = TOTAL_W'(used_ff) + TOTAL_W'(cmd.code.len);
      nw        = total[TOTAL_W-1:USED_W];
      fill      = WC_W'(nw) >= remaining;
      emit      = fill ? remaining[1:0] : nw;
   end

   always_comb begin
      acc_in    = acc_ff;
      used_in   = used_ff;
      words_in  = words_ff;
      full_in   = full_ff;
      vcount_in = vcount_ff;
      push      = '0;
      if (cmd.fire && cmd.flush) begin
         push.count               = 2'd1;
         push.w0.packed_word      = full_ff ? '0 : acc_ff;
         push.w0.bits_valid       = full_ff ? '0 : BITS_W'(used_ff);
         push.w0.end_of_block     = 1'b1;
         push.w0.block_full       = full_ff;
         push.w0.vectors_in_block = vcount_ff;
         push.w0.last             = 1'b1;
         acc_in    = '0;
         used_in   = '0;
         words_in  = '0;
         full_in   = 1'b0;
         vcount_in = '0;
      end else if (cmd.fire && !full_ff) begin
         full_in  = fill;
         words_in = words_ff + WC_W'(emit);
         if (fill) begin
            acc_in  = '0;
            used_in = '0;
         end else begin
            used_in = total[USED_W-1:0];
            case (nw)
               2'd0:    acc_in = cat[WORD_W-1:0];
               2'd1:    acc_in = cat[2*WORD_W-1:WORD_W];
               default: acc_in = WORD_W'(cat[CAT_W-1:2*WORD_W]);
            endcase
         end
         if (cmd.vec_end && !fill && (vcount_ff != sdpe_pkg::VCOUNT_MAX)) begin
            vcount_in = vcount_ff + VCOUNT_W'(1);
         end
         push.count               = emit;
         push.w0.packed_word      = cat[WORD_W-1:0];
         push.w0.bits_valid       = BITS_W'(WORD_W);
         push.w0.end_of_block     = 1'b0;
         push.w0.block_full       = full_in;
         push.w0.vectors_in_block = vcount_in;
         push.w0.last             = (emit == 2'd1);
         push.w1.packed_word      = cat[2*WORD_W-1:WORD_W];
         push.w1.bits_valid       = BITS_W'(WORD_W);
         push.w1.end_of_block     = 1'b0;
         push.w1.block_full       = full_in;
         push.w1.vectors_in_block = vcount_in;
         push.w1.last             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         used_ff   <= '0;
         words_ff  <= '0;
         full_ff   <= 1'b0;
         vcount_ff <= '0;
      end else begin
         acc_ff    <= acc_in;
         used_ff   <= used_in;
         words_ff  <= words_in;
         full_ff   <= full_in;
         vcount_ff <= vcount_in;
      end
   end

   // A full block holds no pending bits.
   assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (acc_ff == '0) && (used_ff == '0))
      else $error("full block still holds pending bits");

   // A flush restarts all block state.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.fire && cmd.flush) |=> (words_ff == '0) && !full_ff && (vcount_ff == '0)
                                  && (used_ff == '0))
      else $error("block state not cleared after flush");

endmodule

[src/sdpe_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder result queue
// Four-word queue taking up to two words per cycle and giving out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module sdpe_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  sdpe_pkg::push_type     push,
   output logic                   room,
   output logic                   head_valid,
   input  logic                   head_ready,
   output sdpe_pkg::rsp_word_type head
);

   localparam int DEPTH = sdpe_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sdpe_pkg::rsp_word_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   always_comb begin
      room       = count_ff <= CNT_W'(DEPTH - 2);
      head_valid = count_ff != '0;
      head       = mem_ff[rd_ptr_ff];
      pop        = head_valid && head_ready;
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
      count_in   = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.w0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.w1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Words are only pushed while two entries are free.
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= CNT_W'(DEPTH - 2)))
      else $error("push into queue without room");

   // The fill count does not change without a push or a pop.
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0) && !pop |=> $stable(count_ff))
      else $error("queue count changed without traffic");

endmodule

[tb/sdpe_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder stream checker
// Follows the register writes and every accepted sample or flush, predicts
// the packed words that each one should produce, and compares every word
// leaving the encoder against the oldest prediction.
// ----------------------------------------------------------------------------
module sdpe_stream_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sdpe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sdpe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   sdpe_req_if                              req,
   sdpe_rsp_if                              rsp,
   output int                               fail_count,
   output int                               outstanding
);
   import sdpe_pkg::*;

   localparam int LANES = DEF_MAX_CHANNELS;

   logic [CHCNT_W-1:0]  chan_cfg;
   logic [PAYW_W-1:0]   payload_cfg;
   logic [15:0]         hist_one [LANES];
   logic [15:0]         hist_two [LANES];
   logic [WORD_W-1:0]   acc;
   int                  free_bits;
   int                  chan_pos;
   phase_type           phase;
   int                  words_out;
   bit                  full;
   logic [VCOUNT_W-1:0] vcount;
   logic [WORD_W-1:0]   fresh_words [$];
   rsp_word_type        predicted_words [$];
   int                  mismatches = 0;

   function automatic int word_cap();
      if (payload_cfg < 1) return 1;
      if (payload_cfg > DEF_BLOCK_WORDS) return DEF_BLOCK_WORDS;
      return int'(payload_cfg);
   endfunction

   function automatic int lane_cap();
      if (chan_cfg < 1) return 1;
      if (chan_cfg > LANES) return LANES;
      return int'(chan_cfg);
   endfunction

   function automatic void open_block();
      acc       = '0;
      free_bits = 16;
      chan_pos  = 0;
      phase     = PHASE_RAW;
      words_out = 0;
      full      = 1'b0;
      vcount    = '0;
   endfunction

   function automatic void emit_bits(input int n, input logic [31:0] v);
      for (int i = 0; i < n; i++) begin
         if (full) return;
         acc[16 - free_bits] = v[i];
         free_bits--;
         if (free_bits == 0) begin
            fresh_words.push_back(acc);
            acc       = '0;
            free_bits = 16;
            words_out++;
            if (words_out >= word_cap()) full = 1'b1;
         end
      end
   endfunction

   function automatic void code_difference(input logic [15:0] d16);
      int d;
      int t;
      d = int'($signed(d16));
      if (d < 0) begin
         t = d - 1;
         if (t < -32768) t = 32'h7fff;
      end else begin
         t = d;
      end
      if (t == 0) begin
         emit_bits(1, 0);
         return;
      end
      for (int k = 1; k <= MAX_CLASS; k++) begin
         if (t >= -(1 << k) && t < (1 << k)) begin
            emit_bits(k + 1, (1 << k) - 1);
            emit_bits(k, t);
            return;
         end
      end
      emit_bits(9, 32'(ESC_PREFIX));
      emit_bits(16, t);
   endfunction

   function automatic void encode_item(input op_type op, input logic [15:0] s);
      int           cl;
      int           c;
      logic [15:0]  p1;
      logic [15:0]  p2;
      logic [15:0]  d16;
      rsp_word_type w;
      if (op == OP_FLUSH) begin
         w.bits_valid       = full ? 5'd0 : 5'(16 - free_bits);
         w.packed_word      = (w.bits_valid == 0) ? '0 : acc;
         w.end_of_block     = 1'b1;
         w.block_full       = full;
         w.vectors_in_block = vcount;
         w.last             = 1'b1;
         predicted_words.push_back(w);
         open_block();
         return;
      end
      fresh_words.delete();
      cl = lane_cap();
      c  = chan_pos;
      if (c >= cl) c = cl - 1;
      p1 = hist_one[c];
      p2 = hist_two[c];
      case (phase)
         PHASE_RAW: begin
            emit_bits(16, s);
         end
         PHASE_FIRST: begin
            d16 = s - p1;
            code_difference(d16);
         end
         default: begin
            d16 = s - {p1[14:0], 1'b0} + p2;
            code_difference(d16);
         end
      endcase
      hist_two[c] = p1;
      hist_one[c] = s;
      if (c + 1 >= cl) begin
         chan_pos = 0;
         phase    = (phase == PHASE_RAW) ? PHASE_FIRST : PHASE_SECOND;
         if (!full && vcount < VCOUNT_MAX) vcount++;
      end else begin
         chan_pos = c + 1;
      end
      foreach (fresh_words[i]) begin
         w.packed_word      = fresh_words[i];
         w.bits_valid       = 5'd16;
         w.end_of_block     = 1'b0;
         w.block_full       = full;
         w.vectors_in_block = vcount;
         w.last             = (i == fresh_words.size() - 1);
         predicted_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         chan_cfg    = CHCNT_RESET;
         payload_cfg = PAYW_RESET;
         foreach (hist_one[i]) begin
            hist_one[i] = '0;
            hist_two[i] = '0;
         end
         open_block();
         predicted_words.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.packed_word      = rsp.packed_word;
            got.bits_valid       = rsp.bits_valid;
            got.end_of_block     = rsp.end_of_block;
            got.block_full       = rsp.block_full;
            got.vectors_in_block = rsp.vectors_in_block;
            got.last             = rsp.last;
            if (predicted_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected word %h bits=%0d eob=%0b full=%0b vec=%0d last=%0b",
                           $realtime, got.packed_word, got.bits_valid, got.end_of_block,
                           got.block_full, got.vectors_in_block, got.last);
            end else begin
               want = predicted_words.pop_front();
               if (got.packed_word !== want.packed_word ||
                   got.bits_valid !== want.bits_valid ||
                   got.end_of_block !== want.end_of_block ||
                   got.block_full !== want.block_full ||
                   got.vectors_in_block !== want.vectors_in_block ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: word mismatch", $realtime);
                     $display("   expected %h bits=%0d eob=%0b full=%0b vec=%0d last=%0b",
                              want.packed_word, want.bits_valid, want.end_of_block,
                              want.block_full, want.vectors_in_block, want.last);
                     $display("   actual   %h bits=%0d eob=%0b full=%0b vec=%0d last=%0b",
                              got.packed_word, got.bits_valid, got.end_of_block,
                              got.block_full, got.vectors_in_block, got.last);
                  end
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: chan_cfg = csr_wdata[CHCNT_W-1:0];
               CSR_PAYLOAD_WORDS: payload_cfg = csr_wdata[PAYW_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) encode_item(op_type'(req.op), req.sample);
      end
      fail_count  <= mismatches;
      outstanding <= predicted_words.size();
   end

endmodule

[tb/tb_second_difference_prefix_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-difference prefix encoder testbench
// Drives directed corner cases and then long runs of mostly smooth
// multi-channel sample streams with occasional flushes across many register
// settings, with random gaps and stalls on both channels, while a checker
// predicts and compares every packed word.
// ----------------------------------------------------------------------------
module tb_second_difference_prefix_encoder_top;
   import sdpe_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;
   bit                    tx_quiet = 1'b0;
   bit                    rx_quiet = 1'b0;
   int                    rx_hold = 0;
   int                    cfg_ch = 1;

   sdpe_req_if req_ch ();
   sdpe_rsp_if rsp_ch ();

   always #4 clock = ~clock;

   second_difference_prefix_encoder_top DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   sdpe_stream_checker stream_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   task automatic send_item(input op_type op, input logic [15:0] s);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.op     <= op;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input int cc, input int pw);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= CSR_DATA_W'(cc);
      @(posedge clock);
      csr_index <= CSR_PAYLOAD_WORDS;
      csr_wdata <= CSR_DATA_W'(pw);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_ch = cc;
   endtask

   // Result side: a random stall before each word, and a long hold when asked.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rx_quiet ? 0 : $urandom_range(0, 15);
         if (rx_hold > 0) begin
            stall   = rx_hold;
            rx_hold = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      int                 phase_ch [10] = '{1, 16, 0, 31, 3, 7, 2, 12, 5, 1};
      int                 phase_pw [10] = '{256, 0, 511, 1, 40, 256, 17, 300, 100, 3};
      int                 odds;
      int                 lanes;
      int                 lane;
      int                 kind;
      int                 mag;
      int                 step;
      logic [15:0]        s;
      logic signed [15:0] trace [16];

      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_CHANNEL_COUNT;
      csr_wdata     <= '0;
      req_ch.valid  <= 1'b0;
      req_ch.op     <= OP_SAMPLE;
      req_ch.sample <= '0;
      foreach (trace[i]) trace[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      settle();
      configure(2, 256);
      send_item(OP_FLUSH, 16'h0000);
      send_item(OP_SAMPLE, 16'h0000);
      send_item(OP_SAMPLE, 16'h7fff);
      send_item(OP_SAMPLE, 16'h8000);
      send_item(OP_SAMPLE, 16'h0000);
      send_item(OP_SAMPLE, 16'h0001);
      send_item(OP_SAMPLE, 16'hffff);
      send_item(OP_SAMPLE, 16'h7fff);
      send_item(OP_SAMPLE, 16'h8000);
      send_item(OP_FLUSH, 16'hffff);

      // The block fills on the first word, then the channel count shrinks
      // below the current position.
      settle();
      configure(8, 1);
      send_item(OP_SAMPLE, 16'd100);
      send_item(OP_SAMPLE, 16'd200);
      send_item(OP_SAMPLE, 16'd300);
      send_item(OP_SAMPLE, 16'd400);
      send_item(OP_SAMPLE, 16'd500);
      settle();
      configure(3, 1);
      send_item(OP_SAMPLE, 16'd7);
      send_item(OP_FLUSH, 16'h5a5a);
      send_item(OP_SAMPLE, 16'd1);
      send_item(OP_FLUSH, 16'h0000);

      for (int ph = 0; ph < 10; ph++) begin
         settle();
         configure(phase_ch[ph], phase_pw[ph]);
         lanes    = (cfg_ch < 1) ? 1 : (cfg_ch > 16) ? 16 : cfg_ch;
         lane     = 0;
         odds     = (phase_pw[ph] <= 4) ? 4 : 40;
         tx_quiet = (ph % 3 == 0) || (ph == 4);
         rx_quiet = (ph % 4 == 1);
         send_item(OP_FLUSH, 16'($urandom));
         if (ph == 4) rx_hold = 300;
         for (int n = 0; n < 185; n++) begin
            if (ph == 6 && n == 90) wait_drained();
            if ($urandom_range(0, odds - 1) == 0) begin
               send_item(OP_FLUSH, 16'($urandom));
               lane = 0;
            end else begin
               kind = $urandom_range(0, 19);
               if (kind < 3) begin
                  s = trace[lane];
               end else if (kind < 15) begin
                  mag  = 1 << $urandom_range(0, 8);
                  step = int'($urandom_range(0, 2 * mag)) - mag;
                  s    = 16'(trace[lane] + step);
               end else if (kind < 18) begin
                  s = 16'($urandom);
               end else begin
                  case ($urandom_range(0, 2))
                     0: s = 16'h7fff;
                     1: s = 16'h8000;
                     default: s = 16'h0000;
                  endcase
               end
               trace[lane] = s;
               send_item(OP_SAMPLE, s);
               lane = (lane + 1) % lanes;
            end
         end
      end

      settle();
      if (fail_count == 0 && outstanding == 0)
         $display("second_difference_prefix_encoder_top verification clean");
      else
         $display("second_difference_prefix_encoder_top verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("second_difference_prefix_encoder_top verification failed");
      $finish;
   end

endmodule
